### rtl/core/swfbp_pkg.sv
// shared types and constants for the swf bit-packed record parser
// command and status structs between controller and datapath
// no dependencies
package swfbp_pkg;

  // record kinds, same coding on op and kind
  typedef enum logic [1:0] {
    KIND_RECT    = 2'd0,
    KIND_MATRIX  = 2'd1,
    KIND_CX_RGB  = 2'd2,
    KIND_CX_RGBA = 2'd3
  } kind_e;

  localparam int unsigned ValueW = 31;

  localparam logic signed [ValueW-1:0] SCALE_ONE = 31'sh0001_0000;
  localparam logic signed [ValueW-1:0] MULT_ONE  = 31'sh0000_0100;

  // source of the next chunk length
  typedef enum logic [2:0] {
    WANT_ONE   = 3'd0,
    WANT_FOUR  = 3'd1,
    WANT_FIVE  = 3'd2,
    WANT_WIDTH = 3'd3,
    WANT_ACC5  = 3'd4,
    WANT_ACC4  = 3'd5
  } want_sel_e;

  // source of an emitted value
  typedef enum logic [1:0] {
    VAL_FIELD = 2'd0,
    VAL_SCALE = 2'd1,
    VAL_MULT  = 2'd2,
    VAL_ZERO  = 2'd3
  } val_sel_e;

  typedef struct packed {
    logic      load;      // take a new byte into the reservoir
    logic      shift;     // move one bit into the accumulator
    logic      want;      // start a new chunk
    want_sel_e want_sel;
    logic      set_w5;    // width from the low five accumulator bits
    logic      set_w4;    // width from the low four accumulator bits
    logic      emit;
    val_sel_e  val_sel;
    logic [1:0] kind;
    logic [2:0] idx;
    logic      present;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic need_zero;
    logic have_bits;
    logic acc_lsb;
    logic emit_ok;
  } dp_sts_t;

endpackage

### rtl/core/swfbp_datapath.sv
// datapath: bit reservoir, chunk accumulator, field width and output register
// depends on swfbp_pkg
module swfbp_datapath import swfbp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic [7:0]               data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [2:0]               field_index_o,
  output logic signed [ValueW-1:0] value_o,
  output logic                     present_o,
  output logic                     last_o
);

  logic [7:0]        res_q, res_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [4:0]        need_q, need_d;
  logic [4:0]        width_q, width_d;
  logic [4:0]        want_bits;
  logic [4:0]        msb_pos;
  logic [ValueW-1:0] hi_mask;
  logic [ValueW-1:0] sext;
  logic signed [ValueW-1:0] val_sel;

  logic                     out_valid_q;
  logic [1:0]               kind_q;
  logic [2:0]               idx_q;
  logic signed [ValueW-1:0] value_q;
  logic                     present_q;
  logic                     last_q;

  always_comb begin
    case (cmd_i.want_sel)
      WANT_ONE:   want_bits = 5'd1;
      WANT_FOUR:  want_bits = 5'd4;
      WANT_FIVE:  want_bits = 5'd5;
      WANT_WIDTH: want_bits = width_q;
      WANT_ACC5:  want_bits = acc_q[4:0];
      WANT_ACC4:  want_bits = {1'b0, acc_q[3:0]};
      default:    want_bits = 5'd0;
    endcase
  end

  // sign extension of the collected field from its width
  assign msb_pos = width_q - 5'd1;
  assign hi_mask = {ValueW{1'b1}} << width_q;
  always_comb begin
    if (width_q == 5'd0) begin
      sext = '0;
    end else if (acc_q[msb_pos]) begin
      sext = acc_q | hi_mask;
    end else begin
      sext = acc_q;
    end
  end

  always_comb begin
    case (cmd_i.val_sel)
      VAL_FIELD: val_sel = sext;
      VAL_SCALE: val_sel = SCALE_ONE;
      VAL_MULT:  val_sel = MULT_ONE;
      default:   val_sel = '0;
    endcase
  end

  always_comb begin
    res_d   = res_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    need_d  = need_q;
    width_d = width_q;
    if (cmd_i.load) begin
      res_d = data_byte_i;
      cnt_d = 4'd8;
    end else if (cmd_i.shift) begin
      res_d  = {res_q[6:0], 1'b0};
      cnt_d  = cnt_q - 4'd1;
      acc_d  = {acc_q[ValueW-2:0], res_q[7]};
      need_d = need_q - 5'd1;
    end
    if (cmd_i.set_w5) begin
      width_d = acc_q[4:0];
    end else if (cmd_i.set_w4) begin
      width_d = {1'b0, acc_q[3:0]};
    end
    if (cmd_i.want) begin
      need_d = want_bits;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      need_q  <= '0;
      width_q <= '0;
    end else begin
      res_q   <= res_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      need_q  <= need_d;
      width_q <= width_d;
    end
  end

  // output register, one beat deep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q    <= cmd_i.kind;
      idx_q     <= cmd_i.idx;
      value_q   <= val_sel;
      present_q <= cmd_i.present;
      last_q    <= cmd_i.last;
    end
  end

  assign sts_o.need_zero = (need_q == 5'd0);
  assign sts_o.have_bits = (cnt_q != 4'd0);
  assign sts_o.acc_lsb   = acc_q[0];
  assign sts_o.emit_ok   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign field_index_o = idx_q;
  assign value_o       = value_q;
  assign present_o     = present_q;
  assign last_o        = last_q;

endmodule

### rtl/core/swfbp_ctrl.sv
// controller: record phase state machine, field index, kind and add flag
// depends on swfbp_pkg; drives swfbp_datapath by command struct
module swfbp_ctrl import swfbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic       start_req_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_R_W     = 20'h00002,
    ST_R_F     = 20'h00004,
    ST_M_SFLAG = 20'h00008,
    ST_M_SW    = 20'h00010,
    ST_M_SF    = 20'h00020,
    ST_M_SDEF  = 20'h00040,
    ST_M_RFLAG = 20'h00080,
    ST_M_RW    = 20'h00100,
    ST_M_RF    = 20'h00200,
    ST_M_RDEF  = 20'h00400,
    ST_M_TW    = 20'h00800,
    ST_M_TF    = 20'h01000,
    ST_C_ADD   = 20'h02000,
    ST_C_MULT  = 20'h04000,
    ST_C_WM    = 20'h08000,
    ST_C_WN    = 20'h10000,
    ST_C_F     = 20'h20000,
    ST_C_MDEF  = 20'h40000,
    ST_C_ADEF  = 20'h80000
  } state_e;

  state_e     st_q, st_d;
  logic [2:0] idx_q, idx_d;
  logic [1:0] kind_q, kind_d;
  logic       add_q, add_d;
  logic       take_byte;
  logic       is_def;
  logic [2:0] mult_last;
  logic [2:0] rec_last;

  assign mult_last = (kind_q == KIND_CX_RGBA) ? 3'd3 : 3'd2;
  assign rec_last  = (kind_q == KIND_CX_RGBA) ? 3'd7 : 3'd5;
  assign is_def    = (st_q == ST_M_SDEF) || (st_q == ST_M_RDEF) ||
                     (st_q == ST_C_MDEF) || (st_q == ST_C_ADEF);

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    kind_d    = kind_q;
    add_d     = add_q;
    take_byte = 1'b0;
    cmd_o          = '0;
    cmd_o.want_sel = WANT_ONE;
    cmd_o.val_sel  = VAL_FIELD;
    cmd_o.kind     = kind_q;
    cmd_o.idx      = idx_q;

    if (st_q == ST_IDLE) begin
      take_byte = 1'b1;
    end else if (is_def) begin
      // default-valued fields, one beat a cycle while the output register can take it
      if (sts_i.emit_ok) begin
        cmd_o.emit = 1'b1;
        case (st_q)
          ST_M_SDEF: begin
            cmd_o.val_sel = VAL_SCALE;
            idx_d = idx_q + 3'd1;
            if (idx_q == 3'd1) begin
              st_d = ST_M_RFLAG;
              cmd_o.want = 1'b1;
              cmd_o.want_sel = WANT_ONE;
            end
          end
          ST_M_RDEF: begin
            cmd_o.val_sel = VAL_ZERO;
            idx_d = idx_q + 3'd1;
            if (idx_q == 3'd3) begin
              st_d = ST_M_TW;
              cmd_o.want = 1'b1;
              cmd_o.want_sel = WANT_FIVE;
            end
          end
          ST_C_MDEF: begin
            cmd_o.val_sel = VAL_MULT;
            idx_d = idx_q + 3'd1;
            if (idx_q == mult_last) begin
              if (add_q) begin
                st_d = ST_C_F;
                cmd_o.want = 1'b1;
                cmd_o.want_sel = WANT_WIDTH;
              end else begin
                st_d = ST_C_ADEF;
              end
            end
          end
          default: begin
            cmd_o.val_sel = VAL_ZERO;
            cmd_o.last = (idx_q == rec_last);
            idx_d = idx_q + 3'd1;
            if (idx_q == rec_last) begin
              st_d = ST_IDLE;
            end
          end
        endcase
      end
    end else if (sts_i.need_zero) begin
      // chunk complete
      case (st_q)
        ST_R_W: begin
          cmd_o.set_w5 = 1'b1;
          idx_d = 3'd0;
          st_d = ST_R_F;
          cmd_o.want = 1'b1;
          cmd_o.want_sel = WANT_ACC5;
        end
        ST_R_F: begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.present = 1'b1;
            cmd_o.last = (idx_q == 3'd3);
            if (idx_q == 3'd3) begin
              st_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 3'd1;
              cmd_o.want = 1'b1;
              cmd_o.want_sel = WANT_WIDTH;
            end
          end
        end
        ST_M_SFLAG: begin
          if (sts_i.acc_lsb) begin
            st_d = ST_M_SW;
            cmd_o.want = 1'b1;
            cmd_o.want_sel = WANT_FIVE;
          end else begin
            idx_d = 3'd0;
            st_d = ST_M_SDEF;
          end
        end
        ST_M_SW, ST_M_RW, ST_M_TW: begin
          cmd_o.set_w5 = 1'b1;
          cmd_o.want = 1'b1;
          cmd_o.want_sel = WANT_ACC5;
          if (st_q == ST_M_SW) begin
            idx_d = 3'd0;
            st_d = ST_M_SF;
          end else if (st_q == ST_M_RW) begin
            idx_d = 3'd2;
            st_d = ST_M_RF;
          end else begin
            idx_d = 3'd4;
            st_d = ST_M_TF;
          end
        end
        ST_M_SF: begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.present = 1'b1;
            idx_d = idx_q + 3'd1;
            cmd_o.want = 1'b1;
            if (idx_q == 3'd1) begin
              st_d = ST_M_RFLAG;
              cmd_o.want_sel = WANT_ONE;
            end else begin
              cmd_o.want_sel = WANT_WIDTH;
            end
          end
        end
        ST_M_RFLAG: begin
          if (sts_i.acc_lsb) begin
            st_d = ST_M_RW;
            cmd_o.want = 1'b1;
            cmd_o.want_sel = WANT_FIVE;
          end else begin
            idx_d = 3'd2;
            st_d = ST_M_RDEF;
          end
        end
        ST_M_RF: begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.present = 1'b1;
            idx_d = idx_q + 3'd1;
            cmd_o.want = 1'b1;
            if (idx_q == 3'd3) begin
              st_d = ST_M_TW;
              cmd_o.want_sel = WANT_FIVE;
            end else begin
              cmd_o.want_sel = WANT_WIDTH;
            end
          end
        end
        ST_M_TF: begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.present = 1'b1;
            cmd_o.last = (idx_q == 3'd5);
            if (idx_q == 3'd5) begin
              st_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 3'd1;
              cmd_o.want = 1'b1;
              cmd_o.want_sel = WANT_WIDTH;
            end
          end
        end
        ST_C_ADD: begin
          add_d = sts_i.acc_lsb;
          st_d = ST_C_MULT;
          cmd_o.want = 1'b1;
          cmd_o.want_sel = WANT_ONE;
        end
        ST_C_MULT: begin
          st_d = sts_i.acc_lsb ? ST_C_WM : ST_C_WN;
          cmd_o.want = 1'b1;
          cmd_o.want_sel = WANT_FOUR;
        end
        ST_C_WM: begin
          cmd_o.set_w4 = 1'b1;
          idx_d = 3'd0;
          st_d = ST_C_F;
          cmd_o.want = 1'b1;
          cmd_o.want_sel = WANT_ACC4;
        end
        ST_C_WN: begin
          // width kept for the add group, mult defaults go out first
          cmd_o.set_w4 = 1'b1;
          idx_d = 3'd0;
          st_d = ST_C_MDEF;
        end
        ST_C_F: begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.present = 1'b1;
            cmd_o.last = (idx_q == rec_last);
            if (idx_q == rec_last) begin
              st_d = ST_IDLE;
            end else if (idx_q == mult_last && !add_q) begin
              idx_d = idx_q + 3'd1;
              st_d = ST_C_ADEF;
            end else begin
              idx_d = idx_q + 3'd1;
              cmd_o.want = 1'b1;
              cmd_o.want_sel = WANT_WIDTH;
            end
          end
        end
        default: begin
          st_d = ST_IDLE;
        end
      endcase
    end else if (sts_i.have_bits) begin
      cmd_o.shift = 1'b1;
    end else begin
      take_byte = 1'b1;
    end

    // a start beat abandons whatever record is open
    if (take_byte && in_valid_i) begin
      if (start_req_i) begin
        kind_d = op_i;
        idx_d  = 3'd0;
        add_d  = 1'b0;
        cmd_o.load = 1'b1;
        cmd_o.want = 1'b1;
        case (op_i)
          KIND_RECT: begin
            st_d = ST_R_W;
            cmd_o.want_sel = WANT_FIVE;
          end
          KIND_MATRIX: begin
            st_d = ST_M_SFLAG;
            cmd_o.want_sel = WANT_ONE;
          end
          default: begin
            st_d = ST_C_ADD;
            cmd_o.want_sel = WANT_ONE;
          end
        endcase
      end else if (st_q != ST_IDLE) begin
        cmd_o.load = 1'b1;
      end
    end
  end

  assign in_stall_o = !take_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      idx_q  <= '0;
      kind_q <= '0;
      add_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      kind_q <= kind_d;
      add_q  <= add_d;
    end
  end

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.emit_ok)
    else $error("field emitted while output register full and stalled");

  a_shift_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift |-> (sts_i.have_bits && !sts_i.need_zero))
    else $error("bit shifted with no bits or no chunk open");

  a_load_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (st_q == ST_IDLE || (!sts_i.have_bits && !sts_i.need_zero)))
    else $error("byte loaded over unconsumed bits or pending chunk");

  a_last_ends_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> st_q == ST_IDLE)
    else $error("record still open after its last field");

endmodule

### rtl/core/swf_bitfield_record_parser_unit.sv
// top level of the swf bit-packed record parser (rect, matrix, cxform)
// instantiates swfbp_ctrl and swfbp_datapath; depends on swfbp_pkg
//
// input channel: one stream byte a beat (data_byte_i), consumed msb first;
//   start_req_i marks the first byte of a new byte-aligned record whose kind
//   is op_i, dropping any open record and leftover bits. bytes without start
//   while no record is open are swallowed.
// output channel: one field a beat (kind, field_index, value, present, last),
//   every field of a record in index order, absent ones with defaults.
// timing: a byte is loaded into the reservoir, then its bits are shifted into
//   the accumulator one per cycle, except while a completed chunk or field is
//   handled or default fields are emitted in sequence, and while a field waits
//   on the output register; the bit-serial accumulator sets this rate.
// the output register is one beat deep: the parser keeps working until it
//   has a field to emit and the register is still held by out_stall_i, then
//   waits; in_stall_o stays high until the current byte is used up.
// reset (rst_ni low, asynchronous) returns to idle with no record open and
//   no output beat pending.
module swf_bitfield_record_parser_unit import swfbp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic                     start_req_i,
  input  logic [7:0]               data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [2:0]               field_index_o,
  output logic signed [ValueW-1:0] value_o,
  output logic                     present_o,
  output logic                     last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  swfbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .start_req_i (start_req_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swfbp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .field_index_o (field_index_o),
    .value_o       (value_o),
    .present_o     (present_o),
    .last_o        (last_o)
  );

endmodule
